// ----- rtl/ejmc_pkg.sv -----
package ejmc_pkg;

  localparam int KEY_SPACE      = 1024;
  localparam int COUNT_BITS     = 32;
  localparam int KEY_BITS       = $clog2(KEY_SPACE);
  localparam int EFF_BITS       = KEY_BITS + 1;
  localparam int NUM_KEYS_BITS  = 11;
  localparam int NUM_KEYS_RESET = 1024;
  localparam int TOTAL_BITS     = 64;
  localparam int PROD_BITS      = 2 * COUNT_BITS;
  localparam int OPCODE_BITS    = 2;
  localparam int S_DATA_BITS    = ((KEY_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS    = TOTAL_BITS;
  localparam int M_USER_BITS    = 2;
  localparam int USER_SAT       = 0;
  localparam int USER_DROP      = 1;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_LEFT   = 2'd0,
    OP_RIGHT  = 2'd1,
    OP_FINISH = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    K_LEFT,
    K_RIGHT,
    K_DROP,
    K_FINISH
  } item_kind_t;

  typedef struct packed {
    item_kind_t          kind;
    logic [KEY_BITS-1:0] key;
  } queue_entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_WRITE,
    BK_SUM,
    BK_OUT
  } back_state_t;

endpackage

// ----- rtl/ejmc_ram.sv -----
module ejmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/ejmc_queue.sv -----
module ejmc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ejmc_pkg::queue_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output ejmc_pkg::queue_entry_t head_entry
);

  ejmc_pkg::queue_entry_t entries [ejmc_pkg::QUEUE_DEPTH];
  logic [ejmc_pkg::QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [ejmc_pkg::QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [ejmc_pkg::QUEUE_PTR_BITS:0]   count;
  logic                                do_push;
  logic                                do_pop;

  assign full       = count == (ejmc_pkg::QUEUE_PTR_BITS + 1)'(ejmc_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_entry = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (ejmc_pkg::QUEUE_PTR_BITS + 1)'(ejmc_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || full) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

// ----- rtl/ejmc_front.sv -----
module ejmc_front (
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ejmc_pkg::S_DATA_BITS-1:0] s_tdata,
  input  logic [ejmc_pkg::OPCODE_BITS-1:0] s_tuser,
  input  logic [ejmc_pkg::EFF_BITS-1:0]    eff_keys,
  input  ejmc_pkg::back_status_t           status,
  input  logic                             q_full,
  output logic                             push,
  output ejmc_pkg::queue_entry_t           push_entry
);

  ejmc_pkg::opcode_t             opcode;
  logic [ejmc_pkg::KEY_BITS-1:0] key;
  logic                          in_range;
  logic                          useful;

  assign opcode   = ejmc_pkg::opcode_t'(s_tuser);
  assign key      = s_tdata[ejmc_pkg::KEY_BITS-1:0];
  assign in_range = ejmc_pkg::EFF_BITS'(key) < eff_keys;
  assign s_tready = !q_full && !status.clearing;
  assign push     = s_tvalid && s_tready && useful;

  always_comb begin
    push_entry.key  = key;
    push_entry.kind = ejmc_pkg::K_DROP;
    useful          = 1'b1;
    unique case (opcode)
      ejmc_pkg::OP_LEFT: begin
        push_entry.kind = in_range ? ejmc_pkg::K_LEFT : ejmc_pkg::K_DROP;
      end
      ejmc_pkg::OP_RIGHT: begin
        push_entry.kind = in_range ? ejmc_pkg::K_RIGHT : ejmc_pkg::K_DROP;
      end
      ejmc_pkg::OP_FINISH: begin
        push_entry.kind = ejmc_pkg::K_FINISH;
      end
      default: begin
        useful = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/ejmc_back.sv -----
module ejmc_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  ejmc_pkg::queue_entry_t           q_entry,
  output logic                             q_pop,
  input  logic [ejmc_pkg::EFF_BITS-1:0]    eff_keys,
  output ejmc_pkg::back_status_t           status,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ejmc_pkg::M_DATA_BITS-1:0] m_tdata,
  output logic [ejmc_pkg::M_USER_BITS-1:0] m_tuser
);

  ejmc_pkg::back_state_t state;
  ejmc_pkg::back_state_t state_next;

  logic [ejmc_pkg::KEY_BITS-1:0]   clr_idx;
  logic [ejmc_pkg::EFF_BITS-1:0]   walk_idx;
  logic                            a_valid;
  logic                            a_in;
  logic [ejmc_pkg::KEY_BITS-1:0]   a_addr;
  logic                            p_valid;
  logic [ejmc_pkg::PROD_BITS-1:0]  p_val;
  logic [ejmc_pkg::TOTAL_BITS-1:0] total;
  logic                            total_sat;
  logic                            overflow_seen;
  logic                            dropped_seen;
  ejmc_pkg::item_kind_t            cur_kind;
  logic [ejmc_pkg::KEY_BITS-1:0]   cur_key;

  logic                            issue;
  logic                            walk_done;
  logic                            out_free;
  logic [ejmc_pkg::KEY_BITS-1:0]   rd_addr;
  logic [ejmc_pkg::KEY_BITS-1:0]   wr_addr;
  logic [ejmc_pkg::COUNT_BITS-1:0] wr_data;
  logic                            we_l;
  logic                            we_r;
  logic [ejmc_pkg::COUNT_BITS-1:0] l_rd;
  logic [ejmc_pkg::COUNT_BITS-1:0] r_rd;
  logic [ejmc_pkg::COUNT_BITS-1:0] side_rd;
  logic                            side_full;
  logic [ejmc_pkg::PROD_BITS-1:0]  prod;
  logic [ejmc_pkg::TOTAL_BITS:0]   sum_wide;

  ejmc_ram #(
    .WIDTH(ejmc_pkg::COUNT_BITS),
    .DEPTH(ejmc_pkg::KEY_SPACE)
  ) u_left_ram (
    .clk    (clk),
    .we     (we_l),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(l_rd)
  );

  ejmc_ram #(
    .WIDTH(ejmc_pkg::COUNT_BITS),
    .DEPTH(ejmc_pkg::KEY_SPACE)
  ) u_right_ram (
    .clk    (clk),
    .we     (we_r),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(r_rd)
  );

  assign issue     = (state == ejmc_pkg::BK_SUM)
                     && (walk_idx < ejmc_pkg::EFF_BITS'(ejmc_pkg::KEY_SPACE));
  assign walk_done = (walk_idx == ejmc_pkg::EFF_BITS'(ejmc_pkg::KEY_SPACE))
                     && !a_valid && !p_valid;
  assign out_free  = !m_tvalid || m_tready;
  assign side_rd   = (cur_kind == ejmc_pkg::K_LEFT) ? l_rd : r_rd;
  assign side_full = &side_rd;
  assign prod      = ejmc_pkg::PROD_BITS'(l_rd) * ejmc_pkg::PROD_BITS'(r_rd);
  assign sum_wide  = {1'b0, total} + (ejmc_pkg::TOTAL_BITS + 1)'(p_val);
  assign status.clearing = state == ejmc_pkg::BK_CLEAR;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ejmc_pkg::BK_CLEAR: begin
        if (clr_idx == ejmc_pkg::KEY_BITS'(ejmc_pkg::KEY_SPACE - 1)) begin
          state_next = ejmc_pkg::BK_IDLE;
        end
      end
      ejmc_pkg::BK_IDLE: begin
        if (q_valid) begin
          unique case (q_entry.kind)
            ejmc_pkg::K_LEFT,
            ejmc_pkg::K_RIGHT:  state_next = ejmc_pkg::BK_WRITE;
            ejmc_pkg::K_FINISH: state_next = ejmc_pkg::BK_SUM;
            default:            state_next = ejmc_pkg::BK_IDLE;
          endcase
        end
      end
      ejmc_pkg::BK_WRITE: begin
        state_next = ejmc_pkg::BK_IDLE;
      end
      ejmc_pkg::BK_SUM: begin
        if (walk_done) begin
          state_next = ejmc_pkg::BK_OUT;
        end
      end
      ejmc_pkg::BK_OUT: begin
        if (out_free) begin
          state_next = ejmc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = ejmc_pkg::BK_CLEAR;
      end
    endcase
  end

  // memory ports and queue pop
  always_comb begin
    q_pop   = 1'b0;
    rd_addr = q_entry.key;
    wr_addr = cur_key;
    wr_data = '0;
    we_l    = 1'b0;
    we_r    = 1'b0;
    unique case (state)
      ejmc_pkg::BK_CLEAR: begin
        wr_addr = clr_idx;
        we_l    = 1'b1;
        we_r    = 1'b1;
      end
      ejmc_pkg::BK_IDLE: begin
        q_pop = q_valid;
      end
      ejmc_pkg::BK_WRITE: begin
        wr_data = side_full ? side_rd : side_rd + 1'b1;
        we_l    = cur_kind == ejmc_pkg::K_LEFT;
        we_r    = cur_kind == ejmc_pkg::K_RIGHT;
      end
      ejmc_pkg::BK_SUM: begin
        rd_addr = walk_idx[ejmc_pkg::KEY_BITS-1:0];
        wr_addr = a_addr;
        we_l    = a_valid;
        we_r    = a_valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ejmc_pkg::BK_CLEAR;
      clr_idx       <= '0;
      walk_idx      <= '0;
      a_valid       <= 1'b0;
      p_valid       <= 1'b0;
      total         <= '0;
      total_sat     <= 1'b0;
      overflow_seen <= 1'b0;
      dropped_seen  <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state   <= state_next;
      a_valid <= issue;
      p_valid <= a_valid;
      if (state == ejmc_pkg::BK_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == ejmc_pkg::BK_IDLE && q_valid) begin
        if (q_entry.kind == ejmc_pkg::K_DROP) begin
          dropped_seen <= 1'b1;
        end
        if (q_entry.kind == ejmc_pkg::K_FINISH) begin
          walk_idx <= '0;
        end
      end
      if (state == ejmc_pkg::BK_WRITE && side_full) begin
        overflow_seen <= 1'b1;
      end
      if (issue) begin
        walk_idx <= walk_idx + 1'b1;
      end
      if (p_valid) begin
        if (sum_wide[ejmc_pkg::TOTAL_BITS]) begin
          total     <= '1;
          total_sat <= 1'b1;
        end else begin
          total <= sum_wide[ejmc_pkg::TOTAL_BITS-1:0];
        end
      end
      if (state == ejmc_pkg::BK_OUT && out_free) begin
        m_tvalid      <= 1'b1;
        total         <= '0;
        total_sat     <= 1'b0;
        overflow_seen <= 1'b0;
        dropped_seen  <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ejmc_pkg::BK_IDLE && q_valid) begin
      cur_kind <= q_entry.kind;
      cur_key  <= q_entry.key;
    end
    a_in   <= walk_idx < eff_keys;
    a_addr <= walk_idx[ejmc_pkg::KEY_BITS-1:0];
    p_val  <= a_in ? prod : '0;
    if (state == ejmc_pkg::BK_OUT && out_free) begin
      m_tdata                      <= total;
      m_tuser[ejmc_pkg::USER_SAT]  <= overflow_seen || total_sat;
      m_tuser[ejmc_pkg::USER_DROP] <= dropped_seen;
    end
  end

  a_write_after_idle: assert property (@(posedge clk) disable iff (rst)
    state == ejmc_pkg::BK_WRITE |-> $past(state) == ejmc_pkg::BK_IDLE)
    else $error("histogram update without a read");

  a_walk_in_sum: assert property (@(posedge clk) disable iff (rst)
    (a_valid || p_valid) |-> state == ejmc_pkg::BK_SUM)
    else $error("sum pipeline busy outside the walk");

  a_pop_in_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ejmc_pkg::BK_IDLE)
    else $error("item popped while busy");

  a_sat_total: assert property (@(posedge clk) disable iff (rst)
    total_sat |-> total == '1)
    else $error("saturated total not at all ones");

endmodule

// ----- rtl/equi_join_match_counter_core.sv -----
// equality join match counter
// s channel: one item per tuple or window end. s_tuser carries the opcode
// (left tuple, right tuple, finish), s_tdata the join key. tuples whose key
// is at or above num_keys are dropped and flagged in the window result.
// m channel: one item per finish, match_count in m_tdata, saturation and
// dropped-key flags in m_tuser. opcode 3 is discarded.
// cfg channel: num_keys, always ready, write only between windows.
// an input item is classified combinationally and written into the queue;
// the back end then takes a tuple through a histogram read (idle) and a
// write state, a dropped tuple through idle alone, and for a finish walks
// every key through the two histogram memories, one 32x32 multiply and a
// 64-bit saturating accumulate, clearing each entry behind the walk. the
// result enters the output register once the walk is done and m is free.
// reset: both histograms are cleared entry by entry; s_tready stays
// low during that pass. a stalled m channel holds the result, the 4-entry
// queue keeps taking items until it fills, then s_tready drops.
module equi_join_match_counter_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ejmc_pkg::S_DATA_BITS-1:0]   s_tdata,   // join_key
  input  logic [ejmc_pkg::OPCODE_BITS-1:0]   s_tuser,   // opcode
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ejmc_pkg::M_DATA_BITS-1:0]   m_tdata,   // match_count
  output logic [ejmc_pkg::M_USER_BITS-1:0]   m_tuser,   // saturated, keys_dropped
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ejmc_pkg::NUM_KEYS_BITS-1:0] cfg_data   // num_keys
);

  logic [ejmc_pkg::NUM_KEYS_BITS-1:0] num_keys;
  logic [ejmc_pkg::EFF_BITS-1:0]      eff_keys;
  ejmc_pkg::back_status_t             status;
  ejmc_pkg::queue_entry_t             push_entry;
  ejmc_pkg::queue_entry_t             head_entry;
  logic                               push;
  logic                               q_full;
  logic                               head_valid;
  logic                               q_pop;

  assign cfg_ready = 1'b1;
  assign eff_keys  = (num_keys > ejmc_pkg::NUM_KEYS_BITS'(ejmc_pkg::KEY_SPACE))
                     ? ejmc_pkg::EFF_BITS'(ejmc_pkg::KEY_SPACE)
                     : ejmc_pkg::EFF_BITS'(num_keys);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_keys <= ejmc_pkg::NUM_KEYS_BITS'(ejmc_pkg::NUM_KEYS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      num_keys <= cfg_data;
    end
  end

  ejmc_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .eff_keys  (eff_keys),
    .status    (status),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  ejmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(head_valid),
    .head_entry(head_entry)
  );

  ejmc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (head_valid),
    .q_entry (head_entry),
    .q_pop   (q_pop),
    .eff_keys(eff_keys),
    .status  (status),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

  localparam int LATENCY     = ejmc_pkg::KEY_SPACE + 16;
  localparam int HOLD_CYCLES = 3000;
  localparam int LIMIT       = 1000000;

  typedef struct {
    logic [ejmc_pkg::TOTAL_BITS-1:0] match_count;
    logic                            saturated;
    logic                            keys_dropped;
  } window_result_t;

  logic                               clk;
  logic                               rst;
  logic                               s_tvalid;
  logic                               s_tready;
  logic [ejmc_pkg::S_DATA_BITS-1:0]   s_tdata;
  logic [ejmc_pkg::OPCODE_BITS-1:0]   s_tuser;
  logic                               m_tvalid;
  logic                               m_tready;
  logic [ejmc_pkg::M_DATA_BITS-1:0]   m_tdata;
  logic [ejmc_pkg::M_USER_BITS-1:0]   m_tuser;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [ejmc_pkg::NUM_KEYS_BITS-1:0] cfg_data;

  logic [ejmc_pkg::COUNT_BITS-1:0]    left_hist [ejmc_pkg::KEY_SPACE];
  logic [ejmc_pkg::COUNT_BITS-1:0]    right_hist [ejmc_pkg::KEY_SPACE];
  logic                               count_overflow;
  logic                               key_dropped;
  logic [ejmc_pkg::NUM_KEYS_BITS-1:0] num_keys;

  window_result_t                     expected_counts[$];
  int                                 errors;
  int                                 cycles;
  int                                 tx_idle_pct;
  int                                 rx_idle_pct;
  logic                               holding;
  event                               hold_output;

  equi_join_match_counter_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // join_key
    .s_tuser   (s_tuser),   // opcode
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // match_count
    .m_tuser   (m_tuser),   // saturated, keys_dropped
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)   // num_keys
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // histogram model
  function automatic int unsigned active_keys();
    return (num_keys > ejmc_pkg::KEY_SPACE) ? ejmc_pkg::KEY_SPACE : num_keys;
  endfunction

  function automatic void clear_histograms();
    foreach (left_hist[k]) begin
      left_hist[k]  = '0;
      right_hist[k] = '0;
    end
    count_overflow = 1'b0;
    key_dropped    = 1'b0;
  endfunction

  function automatic void tally_tuple(logic right_side,
                                      logic [ejmc_pkg::KEY_BITS-1:0] key);
    logic [ejmc_pkg::COUNT_BITS-1:0] cur;
    if (key >= active_keys()) begin
      key_dropped = 1'b1;
      return;
    end
    cur = right_side ? right_hist[key] : left_hist[key];
    if (cur == '1) begin
      count_overflow = 1'b1;
    end else if (right_side) begin
      right_hist[key] = cur + 1'b1;
    end else begin
      left_hist[key] = cur + 1'b1;
    end
  endfunction

  function automatic window_result_t close_window();
    window_result_t                  r;
    logic [ejmc_pkg::TOTAL_BITS-1:0] total;
    logic [ejmc_pkg::TOTAL_BITS-1:0] prod;
    int unsigned                     lim;
    total       = '0;
    r.saturated = count_overflow;
    lim         = active_keys();
    for (int k = 0; k < lim; k++) begin
      prod = ejmc_pkg::TOTAL_BITS'(left_hist[k]) * ejmc_pkg::TOTAL_BITS'(right_hist[k]);
      if (total > ~prod) begin
        total       = '1;
        r.saturated = 1'b1;
      end else begin
        total = total + prod;
      end
    end
    r.match_count  = total;
    r.keys_dropped = key_dropped;
    clear_histograms();
    return r;
  endfunction

  // checks each result against the oldest window total
  always @(posedge clk) begin
    window_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_counts.size() == 0) begin
        $error("unexpected result, match_count %0d", m_tdata);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        if (m_tdata !== want.match_count) begin
          $error("match_count expected %0d actual %0d", want.match_count, m_tdata);
          errors++;
        end
        if (m_tuser[ejmc_pkg::USER_SAT] !== want.saturated) begin
          $error("saturated expected %0d actual %0d", want.saturated,
                 m_tuser[ejmc_pkg::USER_SAT]);
          errors++;
        end
        if (m_tuser[ejmc_pkg::USER_DROP] !== want.keys_dropped) begin
          $error("keys_dropped expected %0d actual %0d", want.keys_dropped,
                 m_tuser[ejmc_pkg::USER_DROP]);
          errors++;
        end
      end
    end
  end

  // output side stalls
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holding) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    holding = 1'b0;
    forever begin
      @(hold_output);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding = 1'b0;
    end
  end

  task automatic send_item(ejmc_pkg::opcode_t op, logic [ejmc_pkg::KEY_BITS-1:0] key);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= ejmc_pkg::S_DATA_BITS'(key);
    do @(posedge clk); while (!s_tready);
    case (op)
      ejmc_pkg::OP_LEFT:   tally_tuple(1'b0, key);
      ejmc_pkg::OP_RIGHT:  tally_tuple(1'b1, key);
      ejmc_pkg::OP_FINISH: expected_counts.push_back(close_window());
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_num_keys(logic [ejmc_pkg::NUM_KEYS_BITS-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    num_keys = value;
  endtask

  task automatic test_basic_window();
    set_num_keys(ejmc_pkg::NUM_KEYS_BITS'(ejmc_pkg::NUM_KEYS_RESET));
    send_item(ejmc_pkg::OP_LEFT, 0);
    send_item(ejmc_pkg::OP_RIGHT, 0);
    send_item(ejmc_pkg::OP_RIGHT, 0);
    send_item(ejmc_pkg::OP_LEFT, 1023);
    send_item(ejmc_pkg::OP_RIGHT, 1023);
    send_item(ejmc_pkg::OP_UNUSED, 1023);
    send_item(ejmc_pkg::OP_FINISH, 1023);
    send_item(ejmc_pkg::OP_FINISH, 0);
  endtask

  task automatic test_key_count();
    // no keys in use
    set_num_keys(0);
    send_item(ejmc_pkg::OP_LEFT, 0);
    send_item(ejmc_pkg::OP_RIGHT, 0);
    send_item(ejmc_pkg::OP_FINISH, 0);
    // single key
    set_num_keys(1);
    send_item(ejmc_pkg::OP_LEFT, 0);
    send_item(ejmc_pkg::OP_RIGHT, 0);
    send_item(ejmc_pkg::OP_LEFT, 1);
    send_item(ejmc_pkg::OP_RIGHT, 1);
    send_item(ejmc_pkg::OP_FINISH, 0);
    // count above the key space
    set_num_keys(2047);
    send_item(ejmc_pkg::OP_LEFT, 1023);
    send_item(ejmc_pkg::OP_RIGHT, 1023);
    send_item(ejmc_pkg::OP_FINISH, 512);
    // shrink mid-window, then make sure the upper keys were cleared
    set_num_keys(1024);
    send_item(ejmc_pkg::OP_LEFT, 5);
    send_item(ejmc_pkg::OP_RIGHT, 5);
    send_item(ejmc_pkg::OP_LEFT, 700);
    send_item(ejmc_pkg::OP_RIGHT, 700);
    set_num_keys(10);
    send_item(ejmc_pkg::OP_FINISH, 0);
    set_num_keys(1024);
    send_item(ejmc_pkg::OP_RIGHT, 700);
    send_item(ejmc_pkg::OP_FINISH, 0);
  endtask

  task automatic test_random_windows(int tx_pct, int rx_pct, int n_items);
    int                                 sent;
    int                                 len;
    int                                 span;
    int                                 lo;
    int                                 eff;
    int                                 r;
    int                                 k;
    logic [ejmc_pkg::NUM_KEYS_BITS-1:0] nk;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0:       nk = 0;
          1:       nk = 2047;
          2:       nk = ejmc_pkg::NUM_KEYS_BITS'($urandom_range(1025, 2046));
          3:       nk = 1024;
          4:       nk = 1;
          default: nk = ejmc_pkg::NUM_KEYS_BITS'($urandom_range(2, 1023));
        endcase
        set_num_keys(nk);
      end
      eff  = active_keys();
      span = $urandom_range(15);
      lo   = (eff > span + 1) ? $urandom_range(eff - span - 1) : 0;
      len  = $urandom_range(1, 14);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(99);
        k = lo + $urandom_range(span + 1);
        if (k > 1023) k = 1023;
        if (r < 5) begin
          send_item(ejmc_pkg::OP_UNUSED, ejmc_pkg::KEY_BITS'($urandom_range(1023)));
        end else begin
          if (r < 12) k = $urandom_range(1023);
          send_item($urandom_range(1) ? ejmc_pkg::OP_RIGHT : ejmc_pkg::OP_LEFT,
                    ejmc_pkg::KEY_BITS'(k));
          sent++;
        end
      end
      send_item(ejmc_pkg::OP_FINISH, ejmc_pkg::KEY_BITS'($urandom_range(1023)));
      sent++;
    end
  endtask

  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_num_keys(64);
    -> hold_output;
    for (int w = 0; w < 4; w++) begin
      for (int i = 0; i < 5; i++) begin
        send_item($urandom_range(1) ? ejmc_pkg::OP_RIGHT : ejmc_pkg::OP_LEFT,
                  ejmc_pkg::KEY_BITS'($urandom_range(7)));
      end
      send_item(ejmc_pkg::OP_FINISH, 0);
    end
  endtask

  initial begin
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= ejmc_pkg::OP_LEFT;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    errors      = 0;
    cycles      = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    num_keys    = ejmc_pkg::NUM_KEYS_BITS'(ejmc_pkg::NUM_KEYS_RESET);
    clear_histograms();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_basic_window();
    test_key_count();
    test_random_windows(19, 88, 180);
    test_random_windows(88, 19, 180);
    test_random_windows(0, 0, 180);
    test_output_stall();

    wait_drained();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
